// ===== hw/rtl/mcds_pkg.sv =====
`default_nettype none
package mcds_pkg;

  // number of health states held in the datapath
  localparam int NUM_STATES = 4;
  // results per matrix are limited to the state count and to four
  localparam int MAX_ACTIVE = (NUM_STATES < 4) ? NUM_STATES : 4;

  localparam int IDX_W  = 2;   // state index width
  localparam int CNT_W  = 3;   // active count width
  localparam int OCC_W  = 32;  // occupancy, unsigned Q16.16
  localparam int PROB_W = 17;  // probability, unsigned Q1.16
  localparam int ACC_W  = 36;  // accumulator, unsigned Q20.16
  localparam int FRAC_W = 16;  // fraction bits of the probability
  localparam int PROD_W = OCC_W + PROB_W;

  localparam int S_TDATA_W = 56;  // 53 bits of fields, padded to bytes
  localparam int M_TDATA_W = 40;  // 34 bits of fields, padded to bytes

  localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(65536);
  localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(4);

  // item kinds carried on the input tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ELEM = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // take the incoming item
    logic load;     // write a start occupancy from the incoming item
    logic mul;      // form the product of the held element
    logic acc;      // add the product into its accumulator
    logic emit;     // push the next state's result to the output register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_elem;    // incoming item is a matrix element
    logic held_last;  // held element ends its matrix
    logic out_free;   // output register can take a result this cycle
    logic emit_last;  // current emission index is the final active state
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mcds_ctrl.sv =====
`default_nettype none
module mcds_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  output mcds_pkg::dp_cmd_t       cmd,
  input  mcds_pkg::dp_status_t    status
);
  import mcds_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // one item in flight at a time
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // command decode
  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.load    = accept && (status.in_elem == CMD_LOAD);
    cmd.mul     = (state == S_MUL);
    cmd.acc     = (state == S_ACC);
    cmd.emit    = (state == S_EMIT) && status.out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (status.in_elem == CMD_ELEM)) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = status.held_last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free && status.emit_last) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a matrix end always leads into emission
  a_last_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && status.held_last) |=> (state == S_EMIT))
    else $error("matrix end did not start emission");

  // results are only pushed into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emission into a busy output register");

  // no new item while a matrix is being emitted
  a_no_accept_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !accept)
    else $error("item accepted during emission");

endmodule
`default_nettype wire

// ===== hw/rtl/mcds_dp.sv =====
`default_nettype none
module mcds_dp (
  input  wire                               clk,
  input  wire                               rst,
  input  mcds_pkg::dp_cmd_t                 cmd,
  output mcds_pkg::dp_status_t              status,
  input  wire                               cfg_wen,
  input  wire  [mcds_pkg::CNT_W-1:0]        cfg_wdata,
  input  wire  [mcds_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  wire                               s_axis_tuser,
  input  wire                               s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [mcds_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import mcds_pkg::*;

  // configuration and state
  logic [CNT_W-1:0]  active_cnt;
  logic [OCC_W-1:0]  occ [NUM_STATES];
  logic [ACC_W-1:0]  acc [NUM_STATES];

  // held element
  logic [IDX_W-1:0]  h_from;
  logic [IDX_W-1:0]  h_to;
  logic [PROB_W-1:0] h_prob;
  logic              h_last;
  logic [OCC_W-1:0]  prod;

  // emission
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  o_index;
  logic [OCC_W-1:0]  o_occ;

  // input fields
  logic [IDX_W-1:0]  in_from;
  logic [IDX_W-1:0]  in_to;
  logic [OCC_W-1:0]  in_occ;
  logic [PROB_W-1:0] in_prob;

  assign in_from = s_axis_tdata[1:0];
  assign in_to   = s_axis_tdata[3:2];
  assign in_occ  = s_axis_tdata[35:4];
  assign in_prob = s_axis_tdata[52:36];

  // effective active count
  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (active_cnt == '0) begin
      n_eff = CNT_W'(1);
    end else if (active_cnt > CNT_W'(MAX_ACTIVE)) begin
      n_eff = CNT_W'(MAX_ACTIVE);
    end else begin
      n_eff = active_cnt;
    end
  end

  // product and saturating sum
  logic [PROB_W-1:0] prob_c;
  logic [PROD_W-1:0] prod_full;
  logic [ACC_W:0]    sum;
  logic              idx_ok;
  logic [ACC_W-1:0]  acc_k;
  logic              k_sat;
  logic [OCC_W-1:0]  k_clip;

  assign prob_c    = (h_prob > PROB_ONE) ? PROB_ONE : h_prob;
  assign prod_full = PROD_W'(occ[h_from]) * PROD_W'(prob_c);
  assign sum       = {1'b0, acc[h_to]} + (ACC_W + 1)'(prod);
  assign idx_ok    = ({1'b0, h_from} < n_eff) && ({1'b0, h_to} < n_eff);
  assign acc_k     = acc[k];
  assign k_sat     = |acc_k[ACC_W-1:OCC_W];
  assign k_clip    = k_sat ? '1 : acc_k[OCC_W-1:0];

  // status
  assign status.in_elem   = s_axis_tuser;
  assign status.held_last = h_last;
  assign status.out_free  = !m_axis_tvalid || m_axis_tready;
  assign status.emit_last = (CNT_W'(k) + CNT_W'(1)) == n_eff;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_cnt <= CNT_RESET;
    end else if (cfg_wen) begin
      active_cnt <= cfg_wdata;
    end
  end

  // held element and product
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      h_from <= in_from;
      h_to   <= in_to;
      h_prob <= in_prob;
      h_last <= s_axis_tlast;
    end
    if (cmd.mul) begin
      prod <= prod_full[FRAC_W+OCC_W-1:FRAC_W];
    end
  end

  // occupancies and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STATES; i++) begin
        occ[i] <= '0;
        acc[i] <= '0;
      end
    end else begin
      if (cmd.load && ({1'b0, in_to} < n_eff)) begin
        occ[in_to] <= in_occ;
      end
      if (cmd.acc && idx_ok) begin
        acc[h_to] <= sum[ACC_W] ? '1 : sum[ACC_W-1:0];
      end
      if (cmd.emit) begin
        occ[k] <= k_clip;
        if (status.emit_last) begin
          for (int i = 0; i < NUM_STATES; i++) begin
            acc[i] <= '0;
          end
        end
      end
    end
  end

  // emission index
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.acc) begin
      k <= '0;
    end else if (cmd.emit) begin
      k <= k + IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_index      <= k;
      o_occ        <= k_clip;
      m_axis_tuser <= k_sat;
      m_axis_tlast <= status.emit_last;
    end
  end

  // tdata: state_index [1:0], occupancy_out [33:2]
  assign m_axis_tdata = {{(M_TDATA_W - OCC_W - IDX_W){1'b0}}, o_occ, o_index};

  // final result of a matrix carries the last active state
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> ((CNT_W'(o_index) + CNT_W'(1)) == n_eff))
    else $error("last result on the wrong state");

  // a clipped result reads as full scale
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (o_occ == '1))
    else $error("saturated result not at full scale");

  // accumulators are empty after the final emission
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.emit_last) |=> (acc[0] == '0 && acc[NUM_STATES-1] == '0))
    else $error("accumulators not cleared after emission");

endmodule
`default_nettype wire

// ===== hw/rtl/markov_cohort_distribution_step_core.sv =====
// load item: taken at accept; matrix element: accepted, then multiplied, then added
// element that ends a matrix: after the add, one result per active state is emitted through
//   the output register, stalled by m_axis_tready
// rate is set by the single multiply-accumulate path, one item in flight at a time
// synchronous active-high reset: occupancies and accumulators zero, active count four
`default_nettype none
module markov_cohort_distribution_step_core (
  input  wire                               clk,
  input  wire                               rst,
  // configuration: active state count
  input  wire                               cfg_wen,
  input  wire  [mcds_pkg::CNT_W-1:0]        cfg_wdata,
  // input items
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // from_state [1:0], to_state [3:2], occupancy_in [35:4], probability [52:36]
  input  wire  [mcds_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // cmd [0]
  input  wire                               s_axis_tuser,
  input  wire                               s_axis_tlast,
  // result items
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // state_index [1:0], occupancy_out [33:2]
  output logic [mcds_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // saturated [0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import mcds_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // control sequencer
  mcds_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd),
    .status        (status)
  );

  // multiply-accumulate datapath and output register
  mcds_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== verif/tb_markov_cohort_distribution_step_core.sv =====
`timescale 1ns / 100ps
module tb_markov_cohort_distribution_step_core;
  import mcds_pkg::*;

  localparam logic [63:0] ACC_LIMIT = (64'd1 << ACC_W) - 1;
  localparam logic [63:0] OCC_LIMIT = (64'd1 << OCC_W) - 1;
  localparam int RANDOM_PHASE_ITEMS = 12;
  localparam int SETTLE_CYCLES = 16;

  // one input item, as the block sees it
  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  from_state;
    logic [IDX_W-1:0]  to_state;
    logic [OCC_W-1:0]  occupancy_in;
    logic [PROB_W-1:0] probability;
    logic              matrix_last;
  } step_item_t;

  // one emitted occupancy
  typedef struct packed {
    logic [IDX_W-1:0] state_index;
    logic [OCC_W-1:0] occupancy;
    logic             saturated;
    logic             last;
  } occ_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // from_state [1:0], to_state [3:2], occupancy_in [35:4], probability [52:36]
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  // cmd [0]
  logic                 s_axis_tuser = 1'b0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // state_index [1:0], occupancy_out [33:2]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // saturated [0]
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  // predictor state
  logic [CNT_W-1:0] count_reg;
  logic [OCC_W-1:0] occ_now [NUM_STATES];
  logic [ACC_W-1:0] acc_next [NUM_STATES];
  occ_result_t      pending_occupancies [$];

  int  errors = 0;
  int  items_used = 0;
  int  results_checked = 0;
  int  count_writes = 0;
  bit  no_idle = 1'b0;
  int  rx_cnt = 0;
  int  rx_wait;

  markov_cohort_distribution_step_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle cycles before an item, zero during burst stretches
  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 5);
  endfunction

  // states in use for the current count register
  function automatic int active_count();
    int c;
    c = int'(count_reg);
    if (c == 0) c = 1;
    if (c > MAX_ACTIVE) c = MAX_ACTIVE;
    return c;
  endfunction

  function automatic logic [OCC_W-1:0] rand_occupancy();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return OCC_W'($urandom_range(0, 32'h0003_FFFF));
      default: return OCC_W'($urandom);
    endcase
  endfunction

  // mostly legal probabilities, with zero, one and values above one
  function automatic logic [PROB_W-1:0] rand_probability();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PROB_ONE;
      2: return PROB_W'($urandom_range(32'h1_0001, 32'h1_FFFF));
      default: return PROB_W'($urandom_range(0, 32'h1_0000));
    endcase
  endfunction

  function automatic step_item_t make_elem(int src, int dst, logic [PROB_W-1:0] prob);
    step_item_t it;
    it.cmd          = CMD_ELEM;
    it.from_state   = IDX_W'(src);
    it.to_state     = IDX_W'(dst);
    it.occupancy_in = OCC_W'($urandom);
    it.probability  = prob;
    it.matrix_last  = 1'b0;
    return it;
  endfunction

  // cohort update: load, multiply-accumulate, and emission at the matrix end
  task automatic advance_cohort(input step_item_t it);
    int              n;
    logic [PROB_W-1:0] p;
    logic [63:0]     prod;
    logic [63:0]     sum;
    occ_result_t     res;
    n = active_count();
    if (it.cmd == CMD_LOAD) begin
      if (int'(it.to_state) < n) begin
        occ_now[it.to_state] = it.occupancy_in;
        items_used++;
      end
      return;
    end
    items_used++;
    p = (it.probability > PROB_ONE) ? PROB_ONE : it.probability;
    if (int'(it.from_state) < n && int'(it.to_state) < n) begin
      prod = (64'(occ_now[it.from_state]) * 64'(p)) >> FRAC_W;
      sum = 64'(acc_next[it.to_state]) + prod;
      if (sum > ACC_LIMIT) sum = ACC_LIMIT;
      acc_next[it.to_state] = sum[ACC_W-1:0];
    end
    if (!it.matrix_last) return;
    for (int k = 0; k < n; k++) begin
      res.state_index = IDX_W'(k);
      res.saturated   = (64'(acc_next[k]) > OCC_LIMIT);
      res.occupancy   = res.saturated ? '1 : acc_next[k][OCC_W-1:0];
      res.last        = (k == n - 1);
      occ_now[k] = res.occupancy;
      pending_occupancies.push_back(res);
    end
    for (int k = 0; k < NUM_STATES; k++) acc_next[k] = '0;
  endtask

  // drive one item and wait for its handshake
  task automatic send_item(input step_item_t it);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tlast  <= it.matrix_last;
    s_axis_tdata  <= S_TDATA_W'({it.probability, it.occupancy_in, it.to_state,
                                 it.from_state});
    do @(posedge clk); while (!s_axis_tready);
    advance_cohort(it);
  endtask

  task automatic send_fields(input logic cmd, input int src, input int dst,
                             input logic [OCC_W-1:0] occ, input logic [PROB_W-1:0] prob,
                             input logic lst);
    step_item_t it;
    it.cmd          = cmd;
    it.from_state   = IDX_W'(src);
    it.to_state     = IDX_W'(dst);
    it.occupancy_in = occ;
    it.probability  = prob;
    it.matrix_last  = lst;
    send_item(it);
  endtask

  // stop sending, drain all expected results, let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_occupancies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    count_reg = value;
    count_writes++;
  endtask

  // untouched state after reset: every occupancy reads zero
  task automatic test_reset_state();
    send_fields(CMD_ELEM, 0, 0, '1, PROB_ONE, 1'b1);
  endtask

  // full-scale loads, clipping of the sum and of a probability above one
  task automatic test_saturation();
    send_fields(CMD_LOAD, 3, 0, '1, '1, 1'b0);
    send_fields(CMD_LOAD, 0, 1, '1, '0, 1'b0);
    send_fields(CMD_LOAD, 1, 2, '1, '1, 1'b0);
    // last mark on a load must not end a matrix
    send_fields(CMD_LOAD, 2, 3, '1, '0, 1'b1);
    send_fields(CMD_ELEM, 0, 0, '0, '1, 1'b0);
    send_fields(CMD_ELEM, 1, 0, '1, PROB_ONE, 1'b0);
    send_fields(CMD_ELEM, 2, 1, '0, PROB_ONE, 1'b0);
    send_fields(CMD_ELEM, 3, 3, '1, PROB_W'(1), 1'b1);
  endtask

  // indices outside the active count are ignored, inactive states are held
  task automatic test_inactive_states();
    write_count(CNT_W'(2));
    send_fields(CMD_LOAD, 0, 3, 32'h1234_5678, '0, 1'b0);
    send_fields(CMD_LOAD, 0, 0, 32'h0001_0000, '0, 1'b0);
    send_fields(CMD_ELEM, 3, 0, '0, PROB_ONE, 1'b0);
    send_fields(CMD_ELEM, 1, 2, '0, PROB_ONE, 1'b0);
    send_fields(CMD_ELEM, 0, 1, '0, PROB_W'(32'h8000), 1'b1);
  endtask

  // count of zero acts as one, count of seven as the full set
  task automatic test_count_extremes();
    write_count(CNT_W'(0));
    send_fields(CMD_LOAD, 0, 1, 32'hDEAD_BEEF, '0, 1'b0);
    send_fields(CMD_ELEM, 0, 0, '0, PROB_ONE, 1'b1);
    write_count(CNT_W'(7));
    send_fields(CMD_ELEM, 3, 2, '0, PROB_ONE, 1'b0);
    send_fields(CMD_ELEM, 2, 3, '0, PROB_W'(32'h8000), 1'b1);
  endtask

  // random chains over a sweep of count settings, with noise and overflow floods
  task automatic test_random_chains();
    step_item_t       mat_q [$];
    step_item_t       it;
    logic [CNT_W-1:0] cnt;
    int               n;
    int               r;
    int               start;
    int               burst;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cnt = 4;
        1: cnt = 1;
        2: cnt = 3;
        3: cnt = 2;
        4: cnt = 7;
        5: cnt = 0;
        6: cnt = 5;
        default: cnt = 6;
      endcase
      write_count(cnt);
      no_idle = (p == 2 || p == 5);
      n = active_count();
      start = items_used;
      while (items_used < start + RANDOM_PHASE_ITEMS) begin
        r = $urandom_range(0, 19);
        if (r < 14) begin
          // well-formed chain: start vector, then one to three matrices
          for (int k = 0; k < n; k++)
            send_fields(CMD_LOAD, $urandom_range(0, 3), k, rand_occupancy(),
                        PROB_W'($urandom), 1'($urandom));
          repeat ($urandom_range(1, 3)) begin
            mat_q.delete();
            for (int i = 0; i < n; i++)
              for (int j = 0; j < n; j++)
                if ($urandom_range(0, 7) != 0)
                  mat_q.push_back(make_elem(i, j, rand_probability()));
            if (n < NUM_STATES && $urandom_range(0, 3) == 0)
              mat_q.push_back(make_elem($urandom_range(n, 3), $urandom_range(0, 3),
                                        rand_probability()));
            if (mat_q.size() == 0)
              mat_q.push_back(make_elem(0, 0, rand_probability()));
            mat_q[mat_q.size() - 1].matrix_last = 1'b1;
            foreach (mat_q[q]) send_item(mat_q[q]);
          end
        end else if (r < 18) begin
          // noise: any field values
          burst = $urandom_range(1, 4);
          repeat (burst) begin
            it.cmd          = 1'($urandom);
            it.from_state   = IDX_W'($urandom);
            it.to_state     = IDX_W'($urandom);
            it.occupancy_in = rand_occupancy();
            it.probability  = PROB_W'($urandom);
            it.matrix_last  = ($urandom_range(0, 3) == 0);
            send_item(it);
          end
        end else begin
          // drive one accumulator past its 36-bit ceiling
          send_fields(CMD_LOAD, 0, 0, '1, '0, 1'b0);
          for (int e = 0; e < 17; e++) begin
            it = make_elem(0, 0, '1);
            it.matrix_last = (e == 16);
            send_item(it);
          end
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // result checking and random output stalls
  task automatic check_result();
    occ_result_t want;
    if (pending_occupancies.size() == 0) begin
      $error("unexpected result: state_index %0d occupancy_out 0x%08h",
             m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W +: OCC_W]);
      errors++;
      return;
    end
    want = pending_occupancies.pop_front();
    results_checked++;
    if (m_axis_tdata[IDX_W-1:0] !== want.state_index) begin
      $error("state_index: expected %0d, got %0d", want.state_index,
             m_axis_tdata[IDX_W-1:0]);
      errors++;
    end
    if (m_axis_tdata[IDX_W +: OCC_W] !== want.occupancy) begin
      $error("occupancy_out: expected 0x%08h, got 0x%08h", want.occupancy,
             m_axis_tdata[IDX_W +: OCC_W]);
      errors++;
    end
    if (m_axis_tuser !== want.saturated) begin
      $error("saturated: expected %0b, got %0b", want.saturated, m_axis_tuser);
      errors++;
    end
    if (m_axis_tlast !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_cnt <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_result();
      rx_wait = draw_wait();
      if (rx_wait != 0) begin
        m_axis_tready <= 1'b0;
        rx_cnt <= rx_wait;
      end
    end else if (!m_axis_tready) begin
      if (rx_cnt <= 1) m_axis_tready <= 1'b1;
      rx_cnt <= rx_cnt - 1;
    end
  end

  // test sequence
  initial begin
    count_reg = CNT_RESET;
    for (int k = 0; k < NUM_STATES; k++) begin
      occ_now[k] = '0;
      acc_next[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_saturation();
    test_inactive_states();
    test_count_extremes();
    test_random_chains();
    settle();
    $display("covered %0d effective items and %0d checked occupancies", items_used,
             results_checked);
    $display("over %0d count writes including 0 and 7, clipping and inactive indices",
             count_writes);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
